### rtl/calendar_date_counter_macros.svh
// Assertion macros for the calendar date counter.
// Included by the top level; depends on nothing else.
`ifndef CALENDAR_DATE_COUNTER_MACROS_SVH
`define CALENDAR_DATE_COUNTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define CDC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("calendar date counter: same-cycle check failed");

// next-cycle implication, checked outside reset
`define CDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("calendar date counter: next-cycle check failed");

`endif

### rtl/cdc_pkg.sv
// Shared types, constants and calendar functions for the date counter.
// Used by cdc_step and calendar_date_counter; no dependencies.
package cdc_pkg;

   localparam logic [11:0] YEAR_MIN = 12'd1900;
   localparam logic [11:0] YEAR_MAX = 12'd3000;
   localparam logic [3:0]  MONTH_JAN = 4'd1;
   localparam logic [3:0]  MONTH_FEB = 4'd2;
   localparam logic [3:0]  MONTH_DEC = 4'd12;
   localparam logic [4:0]  DAY_FIRST = 5'd1;
   localparam logic [4:0]  DAY_LONG  = 5'd31;
   localparam logic [4:0]  DAY_LEAP_FEB = 5'd29;

   localparam logic [4:0] MONTH_LEN [12] =
      '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

   typedef enum logic [1:0] {
      REQ_READ = 2'd0,
      REQ_SET  = 2'd1,
      REQ_NEXT = 2'd2,
      REQ_PREV = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic [11:0] year;
      logic [4:0]  day;
      logic [3:0]  month;
   } date_type;

   // Valid for years within 1900..3000: century years are matched directly.
   function automatic logic is_leap(input logic [11:0] y);
      logic century;
      logic quad_century;
      century      = 1'b0;
      quad_century = 1'b0;
      for (int k = 19; k <= 30; k++) begin
         if (y == 12'(k * 100)) begin
            century = 1'b1;
            if ((k % 4) == 0) begin
               quad_century = 1'b1;
            end
         end
      end
      return (y[1:0] == 2'b00) && (!century || quad_century);
   endfunction

   function automatic logic [4:0] days_in(input logic [3:0] m, input logic [11:0] y);
      logic [3:0] idx;
      idx = m - 4'd1;
      if (m < MONTH_JAN || m > MONTH_DEC) begin
         return DAY_LONG;
      end
      if (m == MONTH_FEB && is_leap(y)) begin
         return DAY_LEAP_FEB;
      end
      return MONTH_LEN[idx];
   endfunction

endpackage

### rtl/cdc_step.sv
// Next-date logic: applies one request to the current date.
// Depends on cdc_pkg.
module cdc_step
   import cdc_pkg::*;
(
   input  date_type     cur_date,
   input  req_kind_type kind,
   input  date_type     new_date,
   output date_type     next_date
);

   logic [3:0] set_month;
   logic [11:0] set_year;
   logic [4:0] set_len;
   logic [4:0] cur_len;
   logic [3:0] prior_month;

   always_comb begin
      set_month = (new_date.month >= MONTH_JAN && new_date.month <= MONTH_DEC)
                  ? new_date.month : MONTH_JAN;
      set_year  = (new_date.year >= YEAR_MIN && new_date.year <= YEAR_MAX)
                  ? new_date.year : YEAR_MIN;
      // day is checked against the new month in the new year
      set_len   = days_in(set_month, set_year);
      cur_len   = days_in(cur_date.month, cur_date.year);
      prior_month = cur_date.month - 4'd1;
   end

   always_comb begin
      next_date = cur_date;
      case (kind)
         REQ_READ: begin
            next_date = cur_date;
         end
         REQ_SET: begin
            next_date.month = set_month;
            next_date.year  = set_year;
            next_date.day   = (new_date.day >= DAY_FIRST && new_date.day <= set_len)
                              ? new_date.day : DAY_FIRST;
         end
         REQ_NEXT: begin
            if (cur_date.day < cur_len) begin
               next_date.day = cur_date.day + 5'd1;
            end else begin
               next_date.day = DAY_FIRST;
               if (cur_date.month >= MONTH_DEC) begin
                  next_date.month = MONTH_JAN;
                  next_date.year  = (cur_date.year >= YEAR_MAX) ? YEAR_MIN
                                    : cur_date.year + 12'd1;
               end else begin
                  next_date.month = cur_date.month + 4'd1;
               end
            end
         end
         REQ_PREV: begin
            if (cur_date.day > DAY_FIRST) begin
               next_date.day = cur_date.day - 5'd1;
            end else if (cur_date.month > MONTH_JAN) begin
               next_date.month = prior_month;
               next_date.day   = days_in(prior_month, cur_date.year);
            end else begin
               // year saturates at the low end
               next_date.month = MONTH_DEC;
               next_date.day   = DAY_LONG;
               next_date.year  = (cur_date.year > YEAR_MIN) ? cur_date.year - 12'd1
                                 : YEAR_MIN;
            end
         end
         default: begin
            next_date = cur_date;
         end
      endcase
   end

endmodule

### rtl/calendar_date_counter.sv
// Calendar date counter: read, set, next-day and previous-day requests.
// Each request word is held in the input register, then its result in the
// result register. Throughput: one request per cycle while rsp_tready does
// not stall the result register; the date register feeds the next-date
// logic and is written in the same cycle the result register loads.
// Reset (synchronous): date becomes January 1 1900, both stages empty.
`include "calendar_date_counter_macros.svh"

module calendar_date_counter
   import cdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] new_month, [8:4] new_day, [20:9] new_year, [23:21] zero
   input  logic [23:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] cur_month, [8:4] cur_day, [20:9] cur_year, [23:21] zero
   output logic [23:0] rsp_tdata
);

   logic         req_valid_ff;
   logic         req_valid_in;
   req_kind_type req_kind_ff;
   date_type     req_date_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   date_type     rsp_date_ff;
   date_type     date_ff;
   date_type     date_in;
   logic         out_free;
   logic         advance;
   logic         date_ok;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = req_valid_ff && out_free;
   assign req_tready = !req_valid_ff || advance;

   assign req_valid_in = (req_tvalid && req_tready) ? 1'b1
                         : (advance ? 1'b0 : req_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   cdc_step u_step (
      .cur_date  (date_ff),
      .kind      (req_kind_ff),
      .new_date  (req_date_ff),
      .next_date (date_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         date_ff      <= '{year: YEAR_MIN, day: DAY_FIRST, month: MONTH_JAN};
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // commit the date only when the result word can load
         if (advance) begin
            date_ff <= date_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_kind_ff       <= req_kind_type'(req_tuser[1:0]);
         req_date_ff.month <= req_tdata[3:0];
         req_date_ff.day   <= req_tdata[8:4];
         req_date_ff.year  <= req_tdata[20:9];
      end
      if (advance) begin
         rsp_date_ff <= date_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_date_ff.year, rsp_date_ff.day, rsp_date_ff.month};

   assign date_ok = (date_ff.month >= MONTH_JAN) && (date_ff.month <= MONTH_DEC)
                    && (date_ff.day >= DAY_FIRST)
                    && (date_ff.day <= days_in(date_ff.month, date_ff.year))
                    && (date_ff.year >= YEAR_MIN) && (date_ff.year <= YEAR_MAX);

   `CDC_ASSERT_NOW(a_date_valid, clock, reset, 1'b1, date_ok)
   `CDC_ASSERT_NOW(a_rsp_matches_state, clock, reset, rsp_valid_ff, (rsp_date_ff == date_ff))
   `CDC_ASSERT_NEXT(a_advance_loads_rsp, clock, reset, advance, (rsp_valid_ff && rsp_date_ff == $past(date_in)))

endmodule

### tb/sv/calendar_date_checker.sv
`timescale 1ns / 1ps
// Date checker for the calendar date counter: watches both streams, keeps its own copy of the date
// and compares each response word in order. Depends on cdc_pkg for the request kinds and date layout.
module calendar_date_checker
   import cdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // [3:0] new_month, [8:4] new_day, [20:9] new_year, [23:21] zero
   input  logic [23:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] cur_month, [8:4] cur_day, [20:9] cur_year, [23:21] zero
   input  logic [23:0] rsp_tdata,
   output int          mismatch_count,
   output int          dates_pending
);

   date_type held_date;
   date_type expected_dates[$];
   int       errors;

   function automatic logic leap_year(input logic [11:0] y);
      int unsigned yi;
      yi = y;
      return (yi % 400 == 0) || ((yi % 4 == 0) && (yi % 100 != 0));
   endfunction

   function automatic logic [4:0] month_length(input logic [3:0] m, input logic [11:0] y);
      case (m)
         4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
         MONTH_FEB:               return leap_year(y) ? 5'd29 : 5'd28;
         default:                 return 5'd31;
      endcase
   endfunction

   function automatic date_type date_after_request(input date_type d, input req_kind_type kind,
                                                   input logic [23:0] word);
      date_type   n;
      logic [3:0]  m;
      logic [4:0]  dy;
      logic [11:0] y;
      n  = d;
      m  = word[3:0];
      dy = word[8:4];
      y  = word[20:9];
      case (kind)
         REQ_SET: begin
            n.month = (m >= MONTH_JAN && m <= MONTH_DEC) ? m : MONTH_JAN;
            n.year  = (y >= YEAR_MIN && y <= YEAR_MAX) ? y : YEAR_MIN;
            // day is validated against the new month in the new year
            n.day   = (dy >= DAY_FIRST && dy <= month_length(n.month, n.year)) ? dy : DAY_FIRST;
         end
         REQ_NEXT: begin
            if (d.day < month_length(d.month, d.year)) begin
               n.day = d.day + 5'd1;
            end else begin
               n.day = DAY_FIRST;
               if (d.month >= MONTH_DEC) begin
                  n.month = MONTH_JAN;
                  n.year  = (d.year >= YEAR_MAX) ? YEAR_MIN : d.year + 12'd1;
               end else begin
                  n.month = d.month + 4'd1;
               end
            end
         end
         REQ_PREV: begin
            if (d.day > DAY_FIRST) begin
               n.day = d.day - 5'd1;
            end else if (d.month > MONTH_JAN) begin
               n.month = d.month - 4'd1;
               n.day   = month_length(n.month, d.year);
            end else begin
               // year saturates at the bottom of the range
               n.month = MONTH_DEC;
               n.day   = DAY_LONG;
               n.year  = (d.year > YEAR_MIN) ? d.year - 12'd1 : YEAR_MIN;
            end
         end
         default: ;
      endcase
      return n;
   endfunction

   always @(posedge clock) begin
      date_type want;
      date_type got;
      if (reset) begin
         held_date.month = MONTH_JAN;
         held_date.day   = DAY_FIRST;
         held_date.year  = YEAR_MIN;
         expected_dates.delete();
         errors = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            held_date = date_after_request(held_date, req_kind_type'(req_tuser), req_tdata);
            expected_dates.push_back(held_date);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[20:0];
            if (expected_dates.size() == 0) begin
               if (errors < 10) begin
                  $display("%0t: response word %h with no request outstanding", $realtime,
                           rsp_tdata);
               end
               errors++;
            end else begin
               want = expected_dates.pop_front();
               if (got.month != want.month || got.day != want.day || got.year != want.year ||
                   rsp_tdata[23:21] != 3'd0) begin
                  if (errors < 10) begin
                     $display("%0t: date mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d pad %b",
                              $realtime, want.month, want.day, want.year,
                              got.month, got.day, got.year, rsp_tdata[23:21]);
                  end
                  errors++;
               end
            end
         end
      end
      mismatch_count <= errors;
      dates_pending  <= expected_dates.size();
   end

endmodule

### tb/sv/tb_calendar_date_counter.sv
`timescale 1ns / 1ps
// Testbench top for the calendar date counter: clock, reset, request stimulus and response stalls.
// Depends on cdc_pkg, the calendar_date_counter RTL and calendar_date_checker.
module tb_calendar_date_counter;
   import cdc_pkg::*;

   localparam int RANDOM_ITEMS = 1350;
   localparam int QUIET_ITEMS  = 150;
   localparam int CYCLE_LIMIT  = 200000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = REQ_READ;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   int mismatch_count;
   int dates_pending;
   int cycle_count = 0;
   int gap_percent = 0;
   bit quiet_tail  = 1'b0;

   always #2 clock = ~clock;

   calendar_date_counter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   calendar_date_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .dates_pending  (dates_pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // hold a word until it is taken; drop valid only for an idle burst
   task automatic send_request(input req_kind_type kind, input logic [3:0] m,
                               input logic [4:0] d, input logic [11:0] y);
      if (!quiet_tail && $urandom_range(0, 99) < gap_percent) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, y, d, m};
      do @(posedge clock); while (!req_tready);
   endtask

   // date fields are ignored by read, next and previous; fill them with noise
   task automatic send_move(input req_kind_type kind);
      send_request(kind, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                   12'($urandom_range(0, 4095)));
   endtask

   function automatic logic [11:0] landmark_year();
      case ($urandom_range(0, 11))
         0:       return 12'd1900;
         1:       return 12'd1901;
         2:       return 12'd2000;
         3:       return 12'd2100;
         4:       return 12'd2400;
         5:       return 12'd2999;
         6:       return 12'd3000;
         7:       return 12'd2004;
         default: return 12'($urandom_range(1900, 3000));
      endcase
   endfunction

   // response side: random stall bursts, always ready in the quiet tail
   initial begin
      @(negedge reset);
      @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin
      int           sent;
      int           walk;
      logic [3:0]   m;
      logic [4:0]   d;
      logic [11:0]  y;
      req_kind_type dir;
      req_kind_type kind;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: range edges, leap rules, month and year rollovers
      send_request(REQ_READ, 4'd0, 5'd0, 12'd0);
      send_request(REQ_PREV, 4'd0, 5'd0, 12'd0);
      send_request(REQ_NEXT, 4'd0, 5'd0, 12'd0);
      send_request(REQ_SET, 4'd12, 5'd31, 12'd3000);
      send_request(REQ_NEXT, 4'd0, 5'd0, 12'd0);
      send_request(REQ_SET, 4'd0, 5'd0, 12'd0);
      send_request(REQ_SET, 4'd15, 5'd31, 12'd4095);
      send_request(REQ_SET, 4'd13, 5'd15, 12'd1899);
      send_request(REQ_SET, 4'd4, 5'd31, 12'd2023);
      send_request(REQ_SET, 4'd2, 5'd29, 12'd1900);
      send_request(REQ_SET, 4'd2, 5'd29, 12'd2000);
      send_request(REQ_PREV, 4'd0, 5'd0, 12'd0);
      send_request(REQ_NEXT, 4'd0, 5'd0, 12'd0);
      send_request(REQ_NEXT, 4'd0, 5'd0, 12'd0);
      send_request(REQ_PREV, 4'd0, 5'd0, 12'd0);
      send_request(REQ_SET, 4'd2, 5'd29, 12'd2100);
      send_request(REQ_SET, 4'd2, 5'd28, 12'd2001);
      send_request(REQ_NEXT, 4'd0, 5'd0, 12'd0);
      send_request(REQ_SET, 4'd3, 5'd1, 12'd1900);
      send_request(REQ_PREV, 4'd0, 5'd0, 12'd0);
      send_request(REQ_SET, 4'd1, 5'd1, 12'd2000);
      send_request(REQ_PREV, 4'd0, 5'd0, 12'd0);
      send_request(REQ_SET, 4'd6, 5'd30, 12'd3001);
      send_request(REQ_SET, 4'd12, 5'd31, 12'd2999);
      send_request(REQ_NEXT, 4'd15, 5'd31, 12'd4095);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         quiet_tail = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
         if (sent % 64 == 0) begin
            case ($urandom_range(0, 2))
               0:       gap_percent = 0;
               1:       gap_percent = 15;
               default: gap_percent = 40;
            endcase
         end
         if ($urandom_range(0, 9) < 6) begin
            // set near a month edge, then walk across it
            y = landmark_year();
            m = 4'($urandom_range(1, 12));
            case ($urandom_range(0, 3))
               0:       d = 5'd1;
               1:       d = 5'($urandom_range(28, 31));
               2:       d = 5'($urandom_range(0, 31));
               default: d = 5'($urandom_range(27, 31));
            endcase
            send_request(REQ_SET, m, d, y);
            sent++;
            dir  = ($urandom_range(0, 1) == 0) ? REQ_NEXT : REQ_PREV;
            walk = $urandom_range(1, 8);
            for (int k = 0; k < walk; k++) begin
               if ($urandom_range(0, 5) == 0) begin
                  send_move((dir == REQ_NEXT) ? REQ_PREV : REQ_NEXT);
               end else if ($urandom_range(0, 9) == 0) begin
                  send_move(REQ_READ);
               end else begin
                  send_move(dir);
               end
               sent++;
            end
         end else begin
            kind = req_kind_type'($urandom_range(0, 3));
            if (kind == REQ_SET && $urandom_range(0, 1) == 0) begin
               send_request(REQ_SET, 4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)),
                            12'($urandom_range(1900, 3000)));
            end else begin
               send_move(kind);
            end
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      while (dates_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### calendar_date_counter.f
+incdir+rtl
rtl/cdc_pkg.sv
rtl/cdc_step.sv
rtl/calendar_date_counter.sv
tb/sv/calendar_date_checker.sv
tb/sv/tb_calendar_date_counter.sv
